### design/brs_pkg.sv
// Shared types, command codes and bit-count helpers for the bitmap set unit.
// No dependencies; imported by brs_front, brs_back and the top level.
package brs_pkg;

   localparam int WORD_BITS   = 16;   // bitmap row width scanned per cycle
   localparam int CMD_W       = 3;
   localparam int ELEM_W      = 8;
   localparam int POS_W       = 9;
   localparam int CNT_W       = 9;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 24;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // command codes on req_tuser
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MEMBER = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RANK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SELECT = 3'd4;

   // classified operation, as queued for the back end
   typedef logic [2:0] op_code_type;
   localparam op_code_type OP_QUERY  = 3'd0;   // member query and unused codes
   localparam op_code_type OP_INSERT = 3'd1;
   localparam op_code_type OP_REMOVE = 3'd2;
   localparam op_code_type OP_RANK   = 3'd3;
   localparam op_code_type OP_SELECT = 3'd4;

   typedef struct packed {
      op_code_type         op;
      logic                in_range;
      logic [ELEM_W-1:0]   element;
      logic [POS_W-1:0]    position;
   } cmd_entry_type;

   typedef struct packed {
      logic [2:0]          pad;
      logic                is_empty;
      logic [CNT_W-1:0]    member_count;
      logic                select_ok;
      logic [POS_W-1:0]    answer;
      logic                is_member;
   } rsp_word_type;

   // popcount of a 16-bit row as an adder tree
   function automatic logic [4:0] pop16(input logic [15:0] w);
      logic [1:0] c2 [8];
      logic [2:0] c4 [4];
      logic [3:0] c8 [2];
      for (int i = 0; i < 8; i++) c2[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
      for (int i = 0; i < 4; i++) c4[i] = {1'b0, c2[2*i]} + {1'b0, c2[2*i+1]};
      for (int i = 0; i < 2; i++) c8[i] = {1'b0, c4[2*i]} + {1'b0, c4[2*i+1]};
      return {1'b0, c8[0]} + {1'b0, c8[1]};
   endfunction

   // bits 0..lo set
   function automatic logic [15:0] low_mask(input logic [3:0] lo);
      return 16'hFFFF >> (4'd15 - lo);
   endfunction

   // position of the r-th set bit (r from 1) of a row, binary search by halves
   function automatic logic [3:0] select_bit(input logic [15:0] w, input logic [4:0] r);
      logic [4:0] rem;
      logic [4:0] c;
      logic [7:0] b8;
      logic [3:0] b4;
      logic [1:0] b2;
      logic [3:0] pos;
      rem = r;
      c = pop16({8'd0, w[7:0]});
      if (rem > c) begin
         pos[3] = 1'b1;
         rem    = rem - c;
         b8     = w[15:8];
      end else begin
         pos[3] = 1'b0;
         b8     = w[7:0];
      end
      c = pop16({12'd0, b8[3:0]});
      if (rem > c) begin
         pos[2] = 1'b1;
         rem    = rem - c;
         b4     = b8[7:4];
      end else begin
         pos[2] = 1'b0;
         b4     = b8[3:0];
      end
      c = pop16({14'd0, b4[1:0]});
      if (rem > c) begin
         pos[1] = 1'b1;
         rem    = rem - c;
         b2     = b4[3:2];
      end else begin
         pos[1] = 1'b0;
         b2     = b4[1:0];
      end
      c = pop16({15'd0, b2[0]});
      pos[0] = (rem > c);
      return pos;
   endfunction

endpackage

### design/brs_front.sv
// Front end: accepts request words, classifies the command and queues it.
// Depends on brs_pkg.
module brs_front #(
   parameter int SET_SIZE = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [brs_pkg::CMD_W-1:0]        req_tuser,   // cmd
   input  logic [brs_pkg::REQ_DATA_W-1:0]   req_tdata,   // element[7:0], position[16:8]
   output logic                             q_valid,
   output brs_pkg::cmd_entry_type           q_entry,
   input  logic                             q_pop
);
   import brs_pkg::*;

   cmd_entry_type     slot_ff [QUEUE_DEPTH];
   cmd_entry_type     new_entry;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              push;

   assign req_tready = (fill_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != '0);
   assign q_entry    = slot_ff[rd_ptr_ff];

   always_comb begin
      case (req_tuser)
         CMD_INSERT: new_entry.op = OP_INSERT;
         CMD_REMOVE: new_entry.op = OP_REMOVE;
         CMD_MEMBER: new_entry.op = OP_QUERY;
         CMD_RANK:   new_entry.op = OP_RANK;
         CMD_SELECT: new_entry.op = OP_SELECT;
         default:    new_entry.op = OP_QUERY;
      endcase
      new_entry.element  = req_tdata[ELEM_W-1:0];
      new_entry.position = req_tdata[ELEM_W+POS_W-1:ELEM_W];
      new_entry.in_range = (32'(req_tdata[ELEM_W-1:0]) < 32'(SET_SIZE));
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, q_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

### design/brs_back.sv
// Back end: bitmap row memory, member count, rank/select row scanner and
// the response register. Depends on brs_pkg.
module brs_back #(
   parameter int SET_SIZE = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  brs_pkg::cmd_entry_type           q_entry,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [brs_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import brs_pkg::*;

   localparam int WORDS = (SET_SIZE + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORDS-1:0]     row_valid_ff;
   logic [WORD_BITS-1:0] rd_word_ff;
   logic                 rd_ok_ff;

   logic [1:0]        state_ff, state_in;
   op_code_type       op_ff, op_in;
   logic              in_range_ff, in_range_in;
   logic [ELEM_W-1:0] elem_ff, elem_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  seen_ff, seen_in;
   logic [ROW_W-1:0]  idx_ff, idx_in;
   logic              member_ff, member_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_ff, rsp_in;

   logic                 start;
   logic [ROW_W-1:0]     rd_addr;
   logic [ROW_W-1:0]     elem_row;
   logic [WORD_BITS-1:0] word;
   logic [WORD_BITS-1:0] bit_onehot;
   logic                 hit;
   logic [4:0]           pc, mpc;
   logic [CNT_W-1:0]     sum;
   logic [POS_W-1:0]     need;
   logic [3:0]           bitpos;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_word;
   logic                 finish;
   logic [POS_W-1:0]     answer;
   logic                 sel_ok;

   assign start      = (state_ff == ST_IDLE) && q_valid && (!rsp_valid_ff || rsp_tready);
   assign q_pop      = start;
   assign elem_row   = ROW_W'(elem_ff[ELEM_W-1:4]);
   assign word       = rd_ok_ff ? rd_word_ff : '0;   // unwritten rows read as empty
   assign bit_onehot = 16'd1 << elem_ff[3:0];
   assign hit        = in_range_ff && word[elem_ff[3:0]];
   assign pc         = pop16(word);
   assign mpc        = pop16(word & low_mask(elem_ff[3:0]));
   assign sum        = seen_ff + CNT_W'(pc);
   assign need       = pos_ff - seen_ff;
   assign bitpos     = select_bit(word, need[4:0]);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE: rd_addr = ROW_W'(q_entry.element[ELEM_W-1:4]);
         ST_LOOK: rd_addr = '0;
         ST_SCAN: rd_addr = idx_ff + 1'b1;
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      in_range_in  = in_range_ff;
      elem_in      = elem_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      seen_in      = seen_ff;
      idx_in       = idx_ff;
      member_in    = member_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_word      = word;
      finish       = 1'b0;
      answer       = '0;
      sel_ok       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in       = q_entry.op;
               in_range_in = q_entry.in_range;
               elem_in     = q_entry.element;
               pos_in      = q_entry.position;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            member_in = hit;
            seen_in   = '0;
            idx_in    = '0;
            case (op_ff)
               OP_INSERT: begin
                  finish = 1'b1;
                  if (!hit && in_range_ff) begin
                     wr_en    = 1'b1;
                     wr_word  = word | bit_onehot;
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_REMOVE: begin
                  finish = 1'b1;
                  if (hit) begin
                     wr_en    = 1'b1;
                     wr_word  = word & ~bit_onehot;
                     count_in = count_ff - 1'b1;
                  end
               end
               OP_RANK: begin
                  if (hit) begin
                     state_in = ST_SCAN;
                  end else begin
                     finish = 1'b1;   // non-member ranks as the total
                     answer = count_ff;
                  end
               end
               OP_SELECT: begin
                  if (pos_ff == '0 || pos_ff > count_ff) begin
                     finish = 1'b1;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               default: finish = 1'b1;
            endcase
         end
         ST_SCAN: begin
            case (op_ff)
               OP_RANK: begin
                  if (idx_ff == elem_row) begin
                     finish = 1'b1;
                     answer = seen_ff + CNT_W'(mpc);
                  end else begin
                     seen_in = sum;
                     idx_in  = idx_ff + 1'b1;
                  end
               end
               OP_SELECT: begin
                  if (sum >= pos_ff) begin
                     finish = 1'b1;
                     sel_ok = 1'b1;
                     answer = POS_W'({idx_ff, bitpos});
                  end else begin
                     seen_in = sum;
                     idx_in  = idx_ff + 1'b1;
                  end
               end
               default: finish = 1'b1;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase

      if (finish) begin
         state_in            = ST_IDLE;
         rsp_valid_in        = 1'b1;
         rsp_in.pad          = '0;
         rsp_in.is_member    = (state_ff == ST_LOOK) ? hit : member_ff;
         rsp_in.answer       = answer;
         rsp_in.select_ok    = sel_ok;
         rsp_in.member_count = count_in;
         rsp_in.is_empty     = (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            row_valid_ff[elem_row] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      in_range_ff <= in_range_in;
      elem_ff     <= elem_in;
      pos_ff      <= pos_in;
      seen_ff     <= seen_in;
      idx_ff      <= idx_in;
      member_ff   <= member_in;
      rsp_ff      <= rsp_in;
   end

   // bitmap rows: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[elem_row] <= wr_word;
      end
      rd_word_ff <= mem[rd_addr];
      rd_ok_ff   <= row_valid_ff[rd_addr];
   end

endmodule

### design/bitmap_set_rank_select_unit.sv
// Bitmap set with rank and select: top level.
// Instantiates brs_front (accept and queue) and brs_back (execute); uses brs_pkg.
//
// Usage:
//  - req channel: one word per command. req_tuser carries the command
//    (insert, remove, member query, rank, select k-th); req_tdata carries the
//    element and the 1-based select position.
//  - rsp channel: exactly one word per command, in command order, with the
//    prior membership of the element, the rank or selected element, the
//    select in-range flag, the member count after the command and emptiness.
//  - A two-word command queue sits between the front and the back, so
//    requests keep being taken while a response waits on rsp_tready.
// Operation (default 256 elements, 16 rows of 16 bits):
//  - insert, remove, member query: the back end reads the element's row and
//    answers, writing the row back for insert and remove; it starts a new
//    command only after it returns to idle.
//  - rank and select: after the same row look-up, rows are scanned from row 0,
//    up to SET_SIZE/16 rows, one at a time through the single row read port.
//  - rsp_tready low holds the response register and stops new commands from
//    starting; the queue then fills and req_tready drops.
// Reset: synchronous, active high. Row valid bits clear on reset, so the
// set is empty and commands are taken right after reset.
module bitmap_set_rank_select_unit #(
   parameter int SET_SIZE = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [brs_pkg::CMD_W-1:0]        req_tuser,   // cmd[2:0]
   input  logic [brs_pkg::REQ_DATA_W-1:0]   req_tdata,   // element[7:0], position[16:8], zero[23:17]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // is_member[0], answer[9:1], select_ok[10], member_count[19:11], is_empty[20], zero[23:21]
   output logic [brs_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import brs_pkg::*;

   logic          q_valid;
   logic          q_pop;
   cmd_entry_type q_entry;

   brs_front #(
      .SET_SIZE (SET_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   brs_back #(
      .SET_SIZE (SET_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
